>>> hdl/fsts_pkg.sv
// fsts_pkg: types and codes for the fair-share task scheduler
// command and result payloads, per-slot memory entry, function/mode/status codes
// no dependencies
`default_nettype none

package fsts_pkg;

    localparam int VR_W   = 64;
    localparam int WT_W   = 17;
    localparam int GRAN_W = 20;

    localparam logic [2:0] FN_TICK   = 3'd0;
    localparam logic [2:0] FN_CREATE = 3'd1;
    localparam logic [2:0] FN_YIELD  = 3'd2;
    localparam logic [2:0] FN_BLOCK  = 3'd3;
    localparam logic [2:0] FN_WAKE   = 3'd4;
    localparam logic [2:0] FN_EXIT   = 3'd5;
    localparam logic [2:0] FN_SETW   = 3'd6;

    localparam logic [1:0] MODE_READY   = 2'd0;
    localparam logic [1:0] MODE_RUNNING = 2'd1;
    localparam logic [1:0] MODE_BLOCKED = 2'd2;
    localparam logic [1:0] MODE_EXITED  = 2'd3;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_UNUSED   = 2'd2;
    localparam logic [1:0] ST_NOT_BLKD = 2'd3;

    localparam logic CFG_MIN_GRAN  = 1'b0;
    localparam logic CFG_WAKE_GRAN = 1'b1;

    localparam logic [WT_W-1:0] SLOT0_WEIGHT = 17'd1024;
    localparam int              WEIGHT_SHIFT = 10;

    typedef struct packed {
        logic [2:0]  func;
        logic [3:0]  slot;
        logic [16:0] weight;
    } cmd_t;

    typedef struct packed {
        logic [3:0] running_slot;
        logic       switched;
        logic [3:0] new_slot;
        logic [1:0] status;
    } res_t;

    typedef struct packed {
        logic [WT_W-1:0] weight;
        logic [VR_W-1:0] vruntime;
        logic [VR_W-1:0] run_start;
        logic [VR_W-1:0] blocked_at;
    } entry_t;

endpackage

`default_nettype wire

>>> hdl/fair_share_task_scheduler.sv
// fair_share_task_scheduler: top level of the fair-share task scheduler
// per-slot times and weights live in one synchronous memory, flags in flops
// depends on fsts_pkg and fsts_div
`default_nettype none

// A command is taken when start is high and busy is low; exactly one result follows,
// shown for one cycle with done high, and it cannot be held off. After reset the block
// sets up slot 0 with busy high. Busy stays high from the accepting edge through the
// result cycle, for a span that depends on the command: a rejected command or an unknown
// function goes straight to the result, set weight reads and rewrites its slot, create
// scans all slots, and a tick, yield, block or exit charges the running task (through the
// divider when time has passed), scans for the minimum and, when the running task
// changes, stamps the new task's start. A wake scans for its floor and may check for
// preemption; a preempting wake adds a full yield. The minimum search reads the entry
// memory one slot per cycle through its one read port.
// Configuration writes must come while busy is low.
module fair_share_task_scheduler
    import fsts_pkg::*;
#(
    parameter int MAX_TASKS = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire cmd_t              cmd,
    output logic                   busy,
    output logic                   done,
    output res_t                   result,
    input  wire logic              cfg_we,
    input  wire logic              cfg_idx,
    input  wire logic [GRAN_W-1:0] cfg_wdata
);

    localparam int SW = (MAX_TASKS > 2) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);

    localparam logic [4:0] S_INIT   = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_CH_RD  = 5'd2;
    localparam logic [4:0] S_CH_DT  = 5'd3;
    localparam logic [4:0] S_CH_DIV = 5'd4;
    localparam logic [4:0] S_CH_WR  = 5'd5;
    localparam logic [4:0] S_SCAN   = 5'd6;
    localparam logic [4:0] S_RS_RD  = 5'd7;
    localparam logic [4:0] S_RS_WR  = 5'd8;
    localparam logic [4:0] S_WK_RD  = 5'd9;
    localparam logic [4:0] S_WK_DT  = 5'd10;
    localparam logic [4:0] S_WK_CR  = 5'd11;
    localparam logic [4:0] S_WK_FL  = 5'd12;
    localparam logic [4:0] S_CV_RD  = 5'd13;
    localparam logic [4:0] S_CV_CMP = 5'd14;
    localparam logic [4:0] S_SW_RD  = 5'd15;
    localparam logic [4:0] S_SW_WR  = 5'd16;
    localparam logic [4:0] S_DONE   = 5'd17;

    localparam logic [1:0] P_SCHED  = 2'd0;
    localparam logic [1:0] P_CREATE = 2'd1;
    localparam logic [1:0] P_WAKE   = 2'd2;

    logic [4:0]        state_reg;
    logic [1:0]        purpose_reg;
    logic              used_reg   [MAX_TASKS];
    logic              queued_reg [MAX_TASKS];
    logic [1:0]        mode_reg   [MAX_TASKS];
    logic [SW-1:0]     running_reg;
    logic [SW-1:0]     before_reg;
    logic [SW-1:0]     tgt_reg;
    logic [CW-1:0]     nf_reg;
    logic [VR_W-1:0]   tick_reg;
    logic [GRAN_W-1:0] min_gran_reg;
    logic [GRAN_W-1:0] wake_gran_reg;
    logic              add_mg_reg;
    logic              blk_reg;
    logic [WT_W-1:0]   wt_in_reg;
    logic [3:0]        new_slot_reg;
    logic [1:0]        status_reg;

    entry_t            mem [MAX_TASKS];
    entry_t            rd_reg;
    entry_t            ent_reg;
    logic [SW-1:0]     raddr;
    logic              we;
    logic [SW-1:0]     waddr;
    entry_t            wdata;

    logic [CW-1:0]     cnt_reg;
    logic              pend_v_reg;
    logic [SW-1:0]     pend_idx_reg;
    logic              found_reg;
    logic [SW-1:0]     best_reg;
    logic [VR_W-1:0]   best_vr_reg;
    logic [VR_W-1:0]   wvr_reg;
    logic [VR_W-1:0]   tmp_reg;

    logic [31:0]       slot_wide;
    logic [SW-1:0]     slot_idx;
    logic              slot_ok;
    logic [VR_W-1:0]   delta;
    logic              div_start;
    logic              div_done;
    logic [VR_W-1:0]   div_q;
    logic [WT_W-1:0]   div_w;
    logic              pend_run;
    logic [VR_W:0]     fl_diff;
    logic [VR_W:0]     cv_diff;
    logic [VR_W-1:0]   final_vr;

    assign slot_wide = 32'(cmd.slot);
    assign slot_idx  = slot_wide[SW-1:0];
    assign slot_ok   = slot_wide < 32'(MAX_TASKS);
    assign delta     = tick_reg - rd_reg.run_start;
    assign div_w     = (rd_reg.weight == '0) ? WT_W'(1) : rd_reg.weight;
    assign div_start = (state_reg == S_CH_DT) && (delta != '0);
    assign pend_run  = used_reg[pend_idx_reg] && queued_reg[pend_idx_reg] &&
                       (mode_reg[pend_idx_reg] == MODE_READY ||
                        mode_reg[pend_idx_reg] == MODE_RUNNING);
    assign fl_diff   = {1'b0, best_vr_reg} - {{(VR_W-GRAN_W+1){1'b0}}, wake_gran_reg};
    assign cv_diff   = {1'b0, rd_reg.vruntime} - {1'b0, wvr_reg};
    assign final_vr  = (wvr_reg < tmp_reg) ? tmp_reg : wvr_reg;

    fsts_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({delta[VR_W-WEIGHT_SHIFT-1:0], {WEIGHT_SHIFT{1'b0}}}),
        .divisor  (div_w),
        .done     (div_done),
        .quotient (div_q)
    );

    // memory port control
    always_comb
    begin
        raddr = running_reg;
        we    = 1'b0;
        waddr = running_reg;
        wdata = ent_reg;
        case (state_reg)
            S_INIT:
            begin
                we    = 1'b1;
                waddr = '0;
                wdata = '{weight: SLOT0_WEIGHT, vruntime: '0, run_start: '0,
                          blocked_at: '0};
            end
            S_CH_WR:
            begin
                we = 1'b1;
                wdata.vruntime = ent_reg.vruntime +
                                 (add_mg_reg ? VR_W'(min_gran_reg) : '0);
            end
            S_SCAN:
            begin
                raddr = cnt_reg[SW-1:0];
                if (cnt_reg == CW'(MAX_TASKS) && !pend_v_reg && purpose_reg == P_CREATE)
                begin
                    we    = 1'b1;
                    waddr = nf_reg[SW-1:0];
                    wdata = '{weight: wt_in_reg,
                              vruntime: found_reg ? best_vr_reg : '0,
                              run_start: '0, blocked_at: '0};
                end
            end
            S_RS_RD:  raddr = running_reg;
            S_RS_WR:
            begin
                we    = 1'b1;
                wdata = rd_reg;
                wdata.run_start = tick_reg;
            end
            S_WK_RD:  raddr = tgt_reg;
            S_WK_FL:
            begin
                we    = 1'b1;
                waddr = tgt_reg;
                wdata.vruntime = final_vr;
            end
            S_CV_RD:  raddr = running_reg;
            S_SW_RD:  raddr = tgt_reg;
            S_SW_WR:
            begin
                we    = 1'b1;
                waddr = tgt_reg;
                wdata = rd_reg;
                wdata.weight = wt_in_reg;
            end
            default:  raddr = running_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_INIT;
            purpose_reg <= P_SCHED;
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                used_reg[i]   <= (i == 0);
                queued_reg[i] <= (i == 0);
                mode_reg[i]   <= (i == 0) ? MODE_RUNNING : MODE_READY;
            end
            running_reg   <= '0;
            before_reg    <= '0;
            tgt_reg       <= '0;
            nf_reg        <= CW'(1);
            tick_reg      <= '0;
            min_gran_reg  <= GRAN_W'(4);
            wake_gran_reg <= GRAN_W'(2);
            add_mg_reg    <= 1'b0;
            blk_reg       <= 1'b0;
            wt_in_reg     <= '0;
            new_slot_reg  <= '0;
            status_reg    <= ST_DONE;
            cnt_reg       <= '0;
            pend_v_reg    <= 1'b0;
            pend_idx_reg  <= '0;
            found_reg     <= 1'b0;
            best_reg      <= '0;
            best_vr_reg   <= '0;
            wvr_reg       <= '0;
            tmp_reg       <= '0;
            ent_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_idx == CFG_MIN_GRAN)
                    min_gran_reg <= cfg_wdata;
                else
                    wake_gran_reg <= cfg_wdata;
            end
            case (state_reg)
                S_INIT: state_reg <= S_IDLE;
                S_IDLE:
                begin
                    if (start)
                    begin
                        before_reg   <= running_reg;
                        tgt_reg      <= slot_idx;
                        wt_in_reg    <= cmd.weight;
                        new_slot_reg <= '0;
                        status_reg   <= ST_DONE;
                        add_mg_reg   <= 1'b0;
                        blk_reg      <= 1'b0;
                        cnt_reg      <= '0;
                        pend_v_reg   <= 1'b0;
                        found_reg    <= 1'b0;
                        case (cmd.func)
                            FN_TICK:
                            begin
                                tick_reg  <= tick_reg + VR_W'(1);
                                state_reg <= S_CH_RD;
                            end
                            FN_CREATE:
                            begin
                                purpose_reg <= P_CREATE;
                                if (nf_reg >= CW'(MAX_TASKS))
                                begin
                                    status_reg <= ST_FULL;
                                    state_reg  <= S_DONE;
                                end
                                else
                                    state_reg <= S_SCAN;
                            end
                            FN_YIELD:
                            begin
                                add_mg_reg <= 1'b1;
                                state_reg  <= S_CH_RD;
                            end
                            FN_BLOCK:
                            begin
                                queued_reg[running_reg] <= 1'b0;
                                mode_reg[running_reg]   <= MODE_BLOCKED;
                                blk_reg   <= 1'b1;
                                state_reg <= S_CH_RD;
                            end
                            FN_WAKE:
                            begin
                                if (!slot_ok || !used_reg[slot_idx])
                                begin
                                    status_reg <= ST_UNUSED;
                                    state_reg  <= S_DONE;
                                end
                                else if (mode_reg[slot_idx] != MODE_BLOCKED)
                                begin
                                    status_reg <= ST_NOT_BLKD;
                                    state_reg  <= S_DONE;
                                end
                                else
                                    state_reg <= S_WK_RD;
                            end
                            FN_EXIT:
                            begin
                                queued_reg[running_reg] <= 1'b0;
                                mode_reg[running_reg]   <= MODE_EXITED;
                                add_mg_reg <= 1'b1;
                                state_reg  <= S_CH_RD;
                            end
                            FN_SETW:
                            begin
                                if (!slot_ok || !used_reg[slot_idx])
                                begin
                                    status_reg <= ST_UNUSED;
                                    state_reg  <= S_DONE;
                                end
                                else
                                    state_reg <= S_SW_RD;
                            end
                            default: state_reg <= S_DONE;
                        endcase
                    end
                end
                S_CH_RD: state_reg <= S_CH_DT;
                S_CH_DT:
                begin
                    ent_reg <= '{weight: rd_reg.weight, vruntime: rd_reg.vruntime,
                                 run_start: tick_reg,
                                 blocked_at: blk_reg ? tick_reg : rd_reg.blocked_at};
                    state_reg <= (delta != '0) ? S_CH_DIV : S_CH_WR;
                end
                S_CH_DIV:
                begin
                    if (div_done)
                    begin
                        ent_reg.vruntime <= ent_reg.vruntime + div_q;
                        state_reg <= S_CH_WR;
                    end
                end
                S_CH_WR:
                begin
                    purpose_reg <= P_SCHED;
                    cnt_reg     <= '0;
                    pend_v_reg  <= 1'b0;
                    found_reg   <= 1'b0;
                    state_reg   <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (cnt_reg != CW'(MAX_TASKS))
                    begin
                        cnt_reg      <= cnt_reg + CW'(1);
                        pend_v_reg   <= 1'b1;
                        pend_idx_reg <= cnt_reg[SW-1:0];
                    end
                    else
                        pend_v_reg <= 1'b0;
                    // strict less-than keeps the lowest index on ties
                    if (pend_v_reg && pend_run &&
                        (!found_reg || rd_reg.vruntime < best_vr_reg))
                    begin
                        found_reg   <= 1'b1;
                        best_reg    <= pend_idx_reg;
                        best_vr_reg <= rd_reg.vruntime;
                    end
                    if (cnt_reg == CW'(MAX_TASKS) && !pend_v_reg)
                    begin
                        case (purpose_reg)
                            P_SCHED:
                            begin
                                if (found_reg && best_reg != running_reg)
                                begin
                                    if (mode_reg[running_reg] == MODE_RUNNING)
                                        mode_reg[running_reg] <= MODE_READY;
                                    mode_reg[best_reg] <= MODE_RUNNING;
                                    running_reg <= best_reg;
                                    state_reg   <= S_RS_RD;
                                end
                                else
                                    state_reg <= S_DONE;
                            end
                            P_CREATE:
                            begin
                                used_reg[nf_reg[SW-1:0]]   <= 1'b1;
                                queued_reg[nf_reg[SW-1:0]] <= 1'b1;
                                mode_reg[nf_reg[SW-1:0]]   <= MODE_READY;
                                new_slot_reg <= 4'(nf_reg);
                                nf_reg       <= nf_reg + CW'(1);
                                state_reg    <= S_DONE;
                            end
                            default:
                            begin
                                // wake floor, saturated at zero
                                tmp_reg <= (found_reg && !fl_diff[VR_W]) ?
                                           fl_diff[VR_W-1:0] : '0;
                                state_reg <= S_WK_FL;
                            end
                        endcase
                    end
                end
                S_RS_RD: state_reg <= S_RS_WR;
                S_RS_WR: state_reg <= S_DONE;
                S_WK_RD: state_reg <= S_WK_DT;
                S_WK_DT:
                begin
                    ent_reg   <= rd_reg;
                    tmp_reg   <= (tick_reg - rd_reg.blocked_at) >> 1;
                    state_reg <= S_WK_CR;
                end
                S_WK_CR:
                begin
                    wvr_reg     <= (ent_reg.vruntime > tmp_reg) ?
                                   ent_reg.vruntime - tmp_reg : '0;
                    purpose_reg <= P_WAKE;
                    cnt_reg     <= '0;
                    pend_v_reg  <= 1'b0;
                    found_reg   <= 1'b0;
                    state_reg   <= S_SCAN;
                end
                S_WK_FL:
                begin
                    wvr_reg             <= final_vr;
                    queued_reg[tgt_reg] <= 1'b1;
                    mode_reg[tgt_reg]   <= MODE_READY;
                    state_reg <= (tgt_reg != running_reg) ? S_CV_RD : S_DONE;
                end
                S_CV_RD: state_reg <= S_CV_CMP;
                S_CV_CMP:
                begin
                    // preempt when running is ahead by more than the margin
                    if (!cv_diff[VR_W] && cv_diff[VR_W-1:0] != '0 &&
                        cv_diff[VR_W-1:0] > VR_W'(wake_gran_reg))
                    begin
                        add_mg_reg <= 1'b1;
                        state_reg  <= S_CH_RD;
                    end
                    else
                        state_reg <= S_DONE;
                end
                S_SW_RD: state_reg <= S_SW_WR;
                S_SW_WR: state_reg <= S_DONE;
                S_DONE:  state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy                = state_reg != S_IDLE;
    assign done                = state_reg == S_DONE;
    assign result.running_slot = 4'(running_reg);
    assign result.switched     = running_reg != before_reg;
    assign result.new_slot     = new_slot_reg;
    assign result.status       = status_reg;

endmodule

`default_nettype wire

>>> hdl/fsts_div.sv
// fsts_div: restoring divider, one quotient bit per cycle
// divides a 64-bit dividend by a 17-bit nonzero divisor
// depends on fsts_pkg
`default_nettype none

module fsts_div
    import fsts_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [VR_W-1:0] dividend,
    input  wire logic [WT_W-1:0] divisor,
    output logic                 done,
    output logic [VR_W-1:0]      quotient
);

    logic [VR_W-1:0] q_reg;
    logic [WT_W:0]   rem_reg;
    logic [WT_W-1:0] d_reg;
    logic [6:0]      cnt_reg;
    logic            run_reg;
    logic            done_reg;
    logic [WT_W:0]   trial;
    logic            fits;

    assign trial = {rem_reg[WT_W-1:0], q_reg[VR_W-1]};
    assign fits  = trial >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'(VR_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            d_reg   <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? trial - {1'b0, d_reg} : trial;
            q_reg   <= {q_reg[VR_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

>>> hdl/fsts_checker.sv
// fsts_checker: port-level checks for the fair-share task scheduler
// bound to fair_share_task_scheduler; depends on fsts_pkg
`default_nettype none

module fsts_checker
    import fsts_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done,
    input wire res_t result
);

    // an accepted transaction keeps the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result strobe longer than one cycle");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe while idle");

    a_new_slot: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.new_slot != 4'd0 |-> result.status == ST_DONE && !result.switched)
        else $error("created slot reported with error or switch");

endmodule

bind fair_share_task_scheduler fsts_checker u_fsts_checker (.*);

`default_nettype wire
